/* rtl/top_n_score_select_defines.svh */
// Assertion macros shared by the checker of the score selection block.
`ifndef TOP_N_SCORE_SELECT_DEFINES_SVH
`define TOP_N_SCORE_SELECT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TNSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TNSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tnss_pkg.sv */
// Types, constants and helper functions of the score selection block.
package tnss_pkg;

  localparam int MAX_KEEP       = 16;
  localparam int MAX_ROW_LENGTH = 4096;

  localparam int SCORE_W    = 16;
  localparam int POS_W      = 12;
  localparam int TAG_W      = 8;
  localparam int KEEP_CNT_W = 5;
  localparam int ROW_POS_W  = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int LIMIT_W    = $clog2(MAX_KEEP + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [SCORE_W-1:0]    THRESHOLD_RESET = 16'd66;
  localparam logic [KEEP_CNT_W-1:0] KEEP_RESET      = 5'd5;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP      = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [SCORE_W-1:0]   score;
    logic [ROW_POS_W-1:0] position;
  } entry_t;

  // Broadcast from the controller to every cell of the list.
  typedef struct packed {
    logic   step;
    logic   admit;
    logic   drain;
    entry_t new_ent;
  } cell_ctl_t;

  // What a cell shows its right-hand neighbor.
  typedef struct packed {
    entry_t ent;
    logic   gt;
  } cell_link_t;

  // True when pair a ranks strictly above pair b; equal scores go by position.
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic res;
    if (a.score != b.score) begin
      res = (a.score > b.score);
    end else begin
      res = (a.position > b.position);
    end
    return res;
  endfunction

endpackage

/* rtl/top_n_score_select.sv */
// Top level of the score selection block: controller, position counter and cell row.
//
// Scores enter one per clock while busy is low, each numbered by its place in
// the row. A row of MAX_KEEP cells holds the best pairs in order; a new score
// is compared against all cells at once and slides in, pushing lower pairs one
// cell along. On the row's last beat busy rises and the list unloads through
// the head cell, one result per cycle; the first result passes the state and
// output registers on its way to the out_ ports. Busy stays high until the
// head cell shows its last kept pair or nothing, after which the next row may
// start at once. Results cannot be held off; out_strobe marks each one for a
// single cycle. Configuration writes take effect on the next accepted score.
module top_n_score_select (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tnss_pkg::SCORE_W-1:0]      in_score,
  input  logic                              in_row_last,
  input  logic [tnss_pkg::TAG_W-1:0]        in_row_tag,
  output logic                              out_strobe,
  output logic [tnss_pkg::SCORE_W-1:0]      out_best_score,
  output logic [tnss_pkg::POS_W-1:0]        out_best_position,
  output logic                              out_found,
  output logic                              out_result_last,
  output logic [tnss_pkg::TAG_W-1:0]        out_result_tag,
  input  logic                              cfg_we,
  input  logic [tnss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tnss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tnss_pkg::state_t                     state_r, state_nxt;
  logic [tnss_pkg::SCORE_W-1:0]         threshold_r;
  logic [tnss_pkg::KEEP_CNT_W-1:0]      keep_count_r;
  logic [tnss_pkg::LIMIT_W-1:0]         k_eff;
  logic [tnss_pkg::ROW_POS_W-1:0]       pos_r, pos_nxt;
  logic [tnss_pkg::TAG_W-1:0]           tag_r;
  logic                                 accept;
  tnss_pkg::cell_ctl_t                  ctl;
  tnss_pkg::cell_link_t                 links [tnss_pkg::MAX_KEEP];
  tnss_pkg::entry_t                     head;
  logic                                 second_valid;

  logic                                 out_strobe_r, out_strobe_nxt;
  logic [tnss_pkg::SCORE_W-1:0]         out_score_r, out_score_nxt;
  logic [tnss_pkg::POS_W-1:0]           out_pos_r, out_pos_nxt;
  logic                                 out_found_r, out_found_nxt;
  logic                                 out_last_r, out_last_nxt;
  logic [tnss_pkg::TAG_W-1:0]           out_tag_r;

  assign accept = start && (state_r == tnss_pkg::ST_IDLE);
  assign busy   = (state_r == tnss_pkg::ST_DRAIN);

  always_comb begin
    if (int'(keep_count_r) > tnss_pkg::MAX_KEEP) begin
      k_eff = tnss_pkg::LIMIT_W'(tnss_pkg::MAX_KEEP);
    end else begin
      k_eff = tnss_pkg::LIMIT_W'(keep_count_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= tnss_pkg::THRESHOLD_RESET;
      keep_count_r <= tnss_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tnss_pkg::REG_THRESHOLD: threshold_r  <= cfg_data[tnss_pkg::SCORE_W-1:0];
        tnss_pkg::REG_KEEP:      keep_count_r <= cfg_data[tnss_pkg::KEEP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counter: saturates, and restarts after the row's last beat.
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_row_last) begin
        pos_nxt = '0;
      end else if (pos_r != tnss_pkg::ROW_POS_W'(tnss_pkg::MAX_ROW_LENGTH - 1)) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_row_last) begin
      tag_r <= in_row_tag;
    end
  end

  always_comb begin
    ctl.step           = accept;
    ctl.admit          = accept && (in_score >= threshold_r);
    ctl.drain          = (state_r == tnss_pkg::ST_DRAIN);
    ctl.new_ent.valid    = 1'b1;
    ctl.new_ent.score    = in_score;
    ctl.new_ent.position = pos_r;
  end

  for (genvar i = 0; i < tnss_pkg::MAX_KEEP; i++) begin : g_cell
    tnss_pkg::cell_link_t left_link;
    tnss_pkg::entry_t     right_ent;
    logic                 keep_ok;

    assign keep_ok = (tnss_pkg::LIMIT_W'(i) < k_eff);

    if (i == 0) begin : g_first
      assign left_link = '0;
    end else begin : g_mid
      assign left_link = links[i-1];
    end

    if (i == tnss_pkg::MAX_KEEP - 1) begin : g_end
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = links[i+1].ent;
    end

    tnss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .keep_ok   (keep_ok),
      .left_link (left_link),
      .right_ent (right_ent),
      .link      (links[i])
    );
  end

  assign head = links[0].ent;

  if (tnss_pkg::MAX_KEEP > 1) begin : g_second
    assign second_valid = links[1].ent.valid;
  end else begin : g_single
    assign second_valid = 1'b0;
  end

  // Next state and the next result beat; an empty list gives one not-found beat.
  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_score_nxt  = head.valid ? head.score : '0;
    out_pos_nxt    = head.valid ? tnss_pkg::POS_W'(head.position) : '0;
    out_found_nxt  = head.valid;
    out_last_nxt   = !head.valid || !second_valid;
    unique case (state_r)
      tnss_pkg::ST_IDLE: begin
        if (accept && in_row_last) begin
          state_nxt = tnss_pkg::ST_DRAIN;
        end
      end
      tnss_pkg::ST_DRAIN: begin
        out_strobe_nxt = 1'b1;
        if (out_last_nxt) begin
          state_nxt = tnss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tnss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tnss_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tnss_pkg::ST_DRAIN) begin
      out_score_r <= out_score_nxt;
      out_pos_r   <= out_pos_nxt;
      out_found_r <= out_found_nxt;
      out_last_r  <= out_last_nxt;
      out_tag_r   <= tag_r;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_best_score    = out_score_r;
  assign out_best_position = out_pos_r;
  assign out_found         = out_found_r;
  assign out_result_last   = out_last_r;
  assign out_result_tag    = out_tag_r;

endmodule

/* rtl/tnss_cell.sv */
// One slot of the sorted insertion list, with its compare and shift logic.
module tnss_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tnss_pkg::cell_ctl_t   ctl,
  input  logic                  keep_ok,
  input  tnss_pkg::cell_link_t  left_link,
  input  tnss_pkg::entry_t      right_ent,
  output tnss_pkg::cell_link_t  link
);

  tnss_pkg::entry_t ent_r;
  tnss_pkg::entry_t ent_nxt;
  tnss_pkg::entry_t eff;
  logic             gt;

  always_comb begin
    eff       = ent_r;
    eff.valid = ent_r.valid & keep_ok;
    gt        = !eff.valid || tnss_pkg::ranks_above(ctl.new_ent, eff);

    ent_nxt = ent_r;
    if (ctl.drain) begin
      ent_nxt = right_ent;
    end else if (ctl.step) begin
      ent_nxt = eff;
      // The first slot the new pair beats takes it; every slot behind it
      // takes what its left neighbor held.
      if (ctl.admit && gt) begin
        ent_nxt = left_link.gt ? left_link.ent : ctl.new_ent;
      end
      ent_nxt.valid = ent_nxt.valid & keep_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign link.ent = eff;
  assign link.gt  = gt;

endmodule

/* rtl/tnss_checker.sv */
// Port-level checker of the score selection block and its bind.
`include "top_n_score_select_defines.svh"

module tnss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            in_row_last,
  input logic                            out_strobe,
  input logic [tnss_pkg::SCORE_W-1:0]    out_best_score,
  input logic [tnss_pkg::POS_W-1:0]      out_best_position,
  input logic                            out_found,
  input logic                            out_result_last
);

  // A not-found beat is the last beat of its row and carries zeros.
  `TNSS_ASSERT_NOW(a_empty_is_last, out_strobe && !out_found, out_result_last, "not-found beat is not last")
  `TNSS_ASSERT_NOW(a_empty_is_zero, out_strobe && !out_found, out_best_score == '0 && out_best_position == '0, "not-found beat carries data")
  // The results of a row come in consecutive cycles.
  `TNSS_ASSERT_NEXT(a_burst_gapless, out_strobe && !out_result_last, out_strobe, "gap inside a result burst")
  // The last beat of a row makes the block busy for its unload.
  `TNSS_ASSERT_NEXT(a_row_end_busy, start && !busy && in_row_last, busy, "not busy after row end")

endmodule

bind top_n_score_select tnss_checker u_tnss_checker (.*);

/* verif/top_n_score_select_checker.sv */
// Checker of the score selection block: predicts each row's results and compares them.
`timescale 1ns / 100ps

module top_n_score_select_checker
  import tnss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [SCORE_W-1:0]    in_score,
  input  logic                  in_row_last,
  input  logic [TAG_W-1:0]      in_row_tag,
  input  logic                  out_strobe,
  input  logic [SCORE_W-1:0]    out_best_score,
  input  logic [POS_W-1:0]      out_best_position,
  input  logic                  out_found,
  input  logic                  out_result_last,
  input  logic [TAG_W-1:0]      out_result_tag,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   position;
    logic               found;
    logic               last;
    logic [TAG_W-1:0]   tag;
  } row_result_t;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_ROW_LENGTH - 1);

  logic [SCORE_W-1:0]    threshold;
  logic [KEEP_CNT_W-1:0] keep_reg;
  logic [SCORE_W-1:0]    list_score [MAX_KEEP];
  logic [POS_W-1:0]      list_pos [MAX_KEEP];
  int                    list_len;
  logic [POS_W-1:0]      row_pos;
  row_result_t           awaited_results [$];
  int                    errs = 0;
  int                    n_waiting = 0;

  assign fail_count    = errs;
  assign pending_count = n_waiting;

  // Appends one expected result beat behind those already waiting.
  function automatic void add_expected(row_result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic bit outranks(logic [SCORE_W-1:0] s_a, logic [POS_W-1:0] p_a,
                                  logic [SCORE_W-1:0] s_b, logic [POS_W-1:0] p_b);
    if (s_a != s_b) begin
      return s_a > s_b;
    end
    return p_a > p_b;
  endfunction

  // Update the best-score list with one score and queue the row's results on its last beat.
  task automatic rank_score(logic [SCORE_W-1:0] s, logic last, logic [TAG_W-1:0] tag);
    int          lim;
    int          slot;
    row_result_t r;
    lim = (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
    // A lowered limit trims the lowest-ranked pairs before the score is looked at.
    if (list_len > lim) list_len = lim;
    if (s >= threshold && lim > 0) begin
      if (list_len < lim) begin
        slot = list_len;
        list_len++;
      end else if (outranks(s, row_pos, list_score[lim-1], list_pos[lim-1])) begin
        slot = lim - 1;
      end else begin
        slot = -1;
      end
      if (slot >= 0) begin
        while (slot > 0 && outranks(s, row_pos, list_score[slot-1], list_pos[slot-1])) begin
          list_score[slot] = list_score[slot-1];
          list_pos[slot]   = list_pos[slot-1];
          slot--;
        end
        list_score[slot] = s;
        list_pos[slot]   = row_pos;
      end
    end
    if (row_pos < POS_MAX) row_pos++;
    if (last) begin
      if (list_len == 0) begin
        r = '{score: '0, position: '0, found: 1'b0, last: 1'b1, tag: tag};
        add_expected(r);
      end else begin
        for (int i = 0; i < list_len; i++) begin
          r = '{score: list_score[i], position: list_pos[i], found: 1'b1,
                last: (i == list_len - 1), tag: tag};
          add_expected(r);
        end
      end
      list_len = 0;
      row_pos  = '0;
    end
  endtask

  task automatic compare_field(string field, logic [SCORE_W-1:0] want,
                               logic [SCORE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    row_result_t w;
    if (!rst_n) begin
      threshold = THRESHOLD_RESET;
      keep_reg  = KEEP_RESET;
      list_len  = 0;
      row_pos   = '0;
      awaited_results.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got score %h position %h",
                   $time, out_best_score, out_best_position);
          errs++;
        end else begin
          w = awaited_results.pop_front();
          compare_field("best_score", w.score, out_best_score);
          compare_field("best_position", SCORE_W'(w.position), SCORE_W'(out_best_position));
          compare_field("found", SCORE_W'(w.found), SCORE_W'(out_found));
          compare_field("result_last", SCORE_W'(w.last), SCORE_W'(out_result_last));
          compare_field("result_tag", SCORE_W'(w.tag), SCORE_W'(out_result_tag));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: threshold = cfg_data;
          REG_KEEP:      keep_reg = cfg_data[KEEP_CNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) rank_score(in_score, in_row_last, in_row_tag);
    end
    n_waiting = awaited_results.size();
  end

endmodule

/* verif/testbench.sv */
// Top of the score selection testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
  import tnss_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 212;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [SCORE_W-1:0]    in_score = '0;
  logic                  in_row_last = 1'b0;
  logic [TAG_W-1:0]      in_row_tag = '0;
  logic                  out_strobe;
  logic [SCORE_W-1:0]    out_best_score;
  logic [POS_W-1:0]      out_best_position;
  logic                  out_found;
  logic                  out_result_last;
  logic [TAG_W-1:0]      out_result_tag;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    check_fails;
  int                    check_pending;
  int                    quiet = 0;
  logic [SCORE_W-1:0]    cur_thr = THRESHOLD_RESET;
  logic [KEEP_CNT_W-1:0] cur_keep = KEEP_RESET;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  top_n_score_select i_dut (
    .clk, .rst_n, .start, .busy, .in_score, .in_row_last, .in_row_tag,
    .out_strobe, .out_best_score, .out_best_position, .out_found, .out_result_last,
    .out_result_tag, .cfg_we, .cfg_index, .cfg_data
  );

  top_n_score_select_checker i_check (
    .clk, .rst_n, .start, .busy, .in_score, .in_row_last, .in_row_tag,
    .out_strobe, .out_best_score, .out_best_position, .out_found, .out_result_last,
    .out_result_tag, .cfg_we, .cfg_index, .cfg_data,
    .fail_count(check_fails), .pending_count(check_pending)
  );

  // Each task starts and ends just after a rising edge.
  task automatic send_score(logic [SCORE_W-1:0] s, logic last, logic [TAG_W-1:0] tag,
                            int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_score    <= s;
    in_row_last <= last;
    in_row_tag  <= tag;
    do @(posedge clk); while (busy);
  endtask

  // Waits until every expected result is out and the last insertion has settled.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (check_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers; the keep count carries junk above its five bits.
  task automatic set_config(logic [SCORE_W-1:0] thr, logic [KEEP_CNT_W-1:0] keep);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_KEEP;
    cfg_data  <= {CFG_DATA_W'($urandom_range(0, 2047)) << KEEP_CNT_W} | CFG_DATA_W'(keep);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_thr  = thr;
    cur_keep = keep;
  endtask

  function automatic logic [SCORE_W-1:0] pick_score(logic [SCORE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return cur_thr;
      3:       return cur_thr - 1'b1;
      4, 5:    return prev;
      default: return SCORE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return THRESHOLD_RESET;
      3:       return SCORE_W'($urandom_range(0, 4095));
      default: return SCORE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [KEEP_CNT_W-1:0] pick_keep();
    case ($urandom_range(0, 6))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      default: return KEEP_CNT_W'($urandom_range(0, 31));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("top_n_score_select test failed");
      $finish;
    end
  end

  initial begin
    int                 items_sent;
    int                 row_len;
    int                 cut_at;
    bit                 calm;
    logic [SCORE_W-1:0] s;
    logic [SCORE_W-1:0] prev;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Default settings: drops below the threshold, a score at it, a tie on the top score.
    send_score(16'hFFFF, 1'b0, 8'h12, 0);
    send_score(16'h0000, 1'b0, 8'h34, 1);
    send_score(16'd65,   1'b0, 8'h56, 0);
    send_score(16'd66,   1'b0, 8'h78, 2);
    send_score(16'hFFFF, 1'b0, 8'h9A, 0);
    send_score(16'h8000, 1'b1, 8'hFF, 0);
    // A row with nothing kept gives the single not-found beat.
    send_score(16'h0000, 1'b1, 8'h00, 3);

    settle();
    set_config(16'h0000, 5'd0);
    send_score(16'hFFFF, 1'b0, 8'hA5, 0);
    send_score(16'h1234, 1'b1, 8'h5A, 0);

    settle();
    set_config(16'hFFFF, 5'd16);
    send_score(16'hFFFE, 1'b0, 8'h01, 0);
    send_score(16'hFFFF, 1'b1, 8'h80, 0);

    // The keep count drops in the middle of a row, so the list is cut.
    settle();
    set_config(16'h0000, 5'd8);
    send_score(16'd100, 1'b0, 8'h11, 0);
    send_score(16'd300, 1'b0, 8'h22, 0);
    send_score(16'd200, 1'b0, 8'h33, 1);
    send_score(16'd400, 1'b0, 8'h44, 0);
    send_score(16'd500, 1'b0, 8'h55, 0);
    settle();
    set_config(16'h0000, 5'd2);
    send_score(16'd50,  1'b0, 8'h66, 0);
    send_score(16'd600, 1'b1, 8'h77, 0);

    items_sent = 0;
    prev = '0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        set_config(pick_threshold(), pick_keep());
      end
      row_len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 10);
      calm    = ($urandom_range(0, 2) == 0);
      cut_at  = (row_len > 2 && $urandom_range(0, 7) == 0) ? $urandom_range(1, row_len - 1) : -1;
      for (int i = 0; i < row_len; i++) begin
        if (i == cut_at) begin
          settle();
          set_config(cur_thr, KEEP_CNT_W'($urandom_range(0, cur_keep)));
        end
        s = pick_score(prev);
        prev = s;
        send_score(s, i == row_len - 1, TAG_W'($urandom_range(0, 255)),
                   calm ? 0 : $urandom_range(0, 16));
        items_sent++;
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (check_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (check_fails == 0 && check_pending == 0) begin
      $display("top_n_score_select test passed");
    end else begin
      $display("top_n_score_select test failed");
    end
    $finish;
  end

endmodule

/* top_n_score_select.f */
+incdir+rtl
rtl/tnss_pkg.sv
rtl/tnss_cell.sv
rtl/top_n_score_select.sv
rtl/tnss_checker.sv
verif/top_n_score_select_checker.sv
verif/testbench.sv
